FILE: rtl/core/uuls_pkg.sv
// shared constants and character helpers for the uudecode line stream unit
package uuls_pkg;

	// line store geometry
	localparam int LINE_MAX = 128;
	localparam int ADDR_W   = $clog2(LINE_MAX);
	localparam int SIZE_W   = $clog2(LINE_MAX + 1);
	localparam int T_W      = SIZE_W + 2;

	// leading characters kept in flops for the banner, end and length checks
	localparam int HEAD_N = 12;
	localparam int HEAD_W = $clog2(HEAD_N);

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;

	localparam logic [7:0] BEGIN_WORD [6] = '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6E, 8'h20};
	localparam logic [7:0] END_WORD   [5] = '{8'h65, 8'h6E, 8'h64, 8'h0D, 8'h0A};

	// outside the printable uuencode range
	function automatic logic bad_char(input logic [7:0] c);
		return (c < 8'd32) || (c > 8'd96);
	endfunction

	function automatic logic [5:0] six_bits(input logic [7:0] c);
		logic [7:0] d;
		d = c - 8'd32;
		return d[5:0];
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/uudecode_line_stream_unit.sv
// uudecode line stream unit: line buffer, section mode machine and group decoder
// flow: a mid-line character is taken while the unit is idle; a line end is followed by
//   evaluation, then for data lines a checking pass and a decoding pass over the data
//   groups (plus any output stall) before the next character is taken
// line store: a single read port, which fetches each four-character group twice
//   (once to find the section end, once to decode)
// reset: arst_n clears mode, counters, state and output valid; the line store is not cleared
module uudecode_line_stream_unit import uuls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] line_char,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_data,
	output logic       last_of_line,
	output logic       still_active
);

	typedef enum logic [2:0] {
		S_IDLE,    // taking characters
		S_EVAL,    // checks on the leading characters
		S_MODE,    // mode step for the finished line
		S_FETCH,   // read one four-character group from the line store
		S_CHECK,   // first pass: find how many groups are good
		S_EMIT,    // second pass: send the group's bytes
		S_STATUS   // single status-only result
	} state_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_BEGUN,
		MODE_DECODE
	} mode_t;

	state_t state_q;
	mode_t  mode_q;

	// line store
	logic [7:0]        mem [LINE_MAX];
	logic [7:0]        rdata_q;
	logic              rd_ok_q;
	logic [SIZE_W-1:0] rd_pos;
	logic [ADDR_W-1:0] rd_addr;
	logic              in_accept;
	logic              store_en;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_q;
	logic [7:0]        head_q [HEAD_N];
	logic [7:0]        last1_q;
	logic [7:0]        last2_q;

	// line evaluation results
	logic              banner_q;
	logic              endl_q;
	logic              empty_q;
	logic              bad0_q;
	logic [5:0]        len_q;
	logic [T_W-1:0]    t_q;

	// group walk
	logic [SIZE_W-1:0] p_q;
	logic [5:0]        rem_q;
	logic [2:0]        k_q;
	logic [7:0]        grp_q [4];
	logic              pass2_q;
	logic [4:0]        ngrp_q;
	logic [4:0]        g_q;
	logic [1:0]        j_q;

	// output register
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              has_data_q;
	logic              last_q;
	logic              active_q;

	assign in_accept = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign store_en  = in_accept && (size_q < SIZE_W'(LINE_MAX));

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign has_data     = has_data_q;
	assign last_of_line = last_q;
	assign still_active = active_q;

	// group fetch address, positions at or past the line length read as zero
	assign rd_pos  = p_q + SIZE_W'(k_q);
	assign rd_addr = rd_pos[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[size_q[ADDR_W-1:0]] <= line_char;
		end
		rdata_q <= mem[rd_addr];
		rd_ok_q <= (rd_pos < n_q);
	end

	logic [7:0] fch;
	assign fch = rd_ok_q ? rdata_q : 8'd0;

	// leading characters as seen through the line length
	logic [7:0]        hch [HEAD_N];
	logic              begin_ok;
	logic              oct_pref;
	logic              banner_c;
	logic              endl_c;
	logic [SIZE_W-1:0] s0;
	logic [SIZE_W-1:0] s1;
	logic [SIZE_W-1:0] body_len;
	logic              drop_lf;
	logic              drop_cr;
	logic [7:0]        tail_ch;
	logic [T_W-1:0]    t_c;

	always_comb begin
		for (int i = 0; i < HEAD_N; i++) begin
			hch[i] = (SIZE_W'(i) < n_q) ? head_q[i] : 8'd0;
		end

		// begin banner
		begin_ok = 1'b1;
		for (int i = 0; i < 6; i++) begin
			if (hch[i] != BEGIN_WORD[i]) begin
				begin_ok = 1'b0;
			end
		end
		oct_pref = 1'b1;
		banner_c = 1'b0;
		for (int i = 7; i <= 10; i++) begin
			if (oct_pref && hch[i] == CH_SPACE && hch[i+1] != CH_CR) begin
				banner_c = 1'b1;
			end
			oct_pref = oct_pref && (hch[i] >= CH_ZERO) && (hch[i] <= CH_SEVEN);
		end
		banner_c = banner_c && begin_ok && (n_q >= SIZE_W'(11));

		// end line, letters case-blind
		endl_c = (n_q >= SIZE_W'(3)) && (n_q <= SIZE_W'(5));
		for (int i = 0; i < 5; i++) begin
			if (SIZE_W'(i) < n_q && to_lower(hch[i]) != END_WORD[i]) begin
				endl_c = 1'b0;
			end
		end

		// data length without trailing lf and cr
		s0       = n_q - SIZE_W'(1);
		drop_lf  = (s0 != '0) && (last1_q == CH_LF);
		s1       = s0 - SIZE_W'(drop_lf);
		tail_ch  = drop_lf ? last2_q : last1_q;
		drop_cr  = (s1 != '0) && (tail_ch == CH_CR);
		body_len = s1 - SIZE_W'(drop_cr);
		t_c      = (T_W'(body_len) + {body_len, 1'b0}) >> 2;
	end

	// strict length compare: (len + 2) / 3 against t / 3
	logic [12:0]    ql_prod;
	logic [5:0]     ql;
	logic [7:0]     ql3;
	logic           strict_ok;

	always_comb begin
		ql_prod   = 13'({1'b0, len_q} + 7'd2) * 13'd43;
		ql        = ql_prod[12:7];
		ql3       = 8'({ql, 1'b0}) + 8'(ql);
		strict_ok = (t_q >= T_W'(ql3)) && (t_q < T_W'(ql3) + T_W'(3));
	end

	// decode line decisions
	logic dec_stop_idle;
	logic dec_run;
	assign dec_stop_idle = endl_q || (!empty_q && bad0_q);
	assign dec_run       = !endl_q && !empty_q && !bad0_q && (len_q != 6'd0);

	// current group
	logic [5:0] sa, sb, sc, sd;
	logic       bad_grp;
	logic [7:0] grp_byte;
	logic       j_last;
	logic       g_last;
	logic [4:0] ngrp_nx;
	logic [2:0] km1;
	logic       out_free;

	always_comb begin
		sa = six_bits(grp_q[0]);
		sb = six_bits(grp_q[1]);
		sc = six_bits(grp_q[2]);
		sd = six_bits(grp_q[3]);
		bad_grp = bad_char(grp_q[0]) || bad_char(grp_q[1]) ||
			((rem_q > 6'd1) && bad_char(grp_q[2])) ||
			((rem_q > 6'd2) && bad_char(grp_q[3]));
		case (j_q)
			2'd0:    grp_byte = {sa, sb[5:4]};
			2'd1:    grp_byte = {sb[3:0], sc[5:2]};
			default: grp_byte = {sc[1:0], sd};
		endcase
		j_last   = (rem_q >= 6'd3) ? (j_q == 2'd2) : (j_q == 2'(rem_q - 6'd1));
		g_last   = (g_q == ngrp_q - 5'd1);
		ngrp_nx  = ngrp_q + 5'(!bad_grp);
		km1      = k_q - 3'd1;
		out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_IDLE;
			size_q      <= '0;
			n_q         <= '0;
			for (int i = 0; i < HEAD_N; i++) begin
				head_q[i] <= 8'd0;
			end
			last1_q     <= 8'd0;
			last2_q     <= 8'd0;
			banner_q    <= 1'b0;
			endl_q      <= 1'b0;
			empty_q     <= 1'b0;
			bad0_q      <= 1'b0;
			len_q       <= 6'd0;
			t_q         <= '0;
			p_q         <= '0;
			rem_q       <= 6'd0;
			k_q         <= 3'd0;
			for (int i = 0; i < 4; i++) begin
				grp_q[i] <= 8'd0;
			end
			pass2_q     <= 1'b0;
			ngrp_q      <= 5'd0;
			g_q         <= 5'd0;
			j_q         <= 2'd0;
			out_valid_q <= 1'b0;
			out_byte_q  <= 8'd0;
			has_data_q  <= 1'b0;
			last_q      <= 1'b0;
			active_q    <= 1'b0;
		end else begin
			// result taken downstream
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						// characters past the store depth are dropped
						if (store_en) begin
							if (size_q < SIZE_W'(HEAD_N)) begin
								head_q[size_q[HEAD_W-1:0]] <= line_char;
							end
							last2_q <= last1_q;
							last1_q <= line_char;
							size_q  <= size_q + SIZE_W'(1);
						end
						if (end_of_line) begin
							n_q     <= size_q + SIZE_W'(store_en);
							size_q  <= '0;
							state_q <= S_EVAL;
						end
					end
				end

				S_EVAL: begin
					banner_q <= banner_c;
					endl_q   <= endl_c;
					empty_q  <= (hch[0] == CH_CR) || (hch[0] == CH_LF);
					bad0_q   <= bad_char(hch[0]);
					len_q    <= six_bits(hch[0]);
					t_q      <= t_c;
					state_q  <= S_MODE;
				end

				S_MODE: begin
					p_q     <= SIZE_W'(1);
					rem_q   <= len_q;
					k_q     <= 3'd0;
					ngrp_q  <= 5'd0;
					g_q     <= 5'd0;
					j_q     <= 2'd0;
					pass2_q <= 1'b0;
					case (mode_q)
						MODE_BEGUN: begin
							// first line after the banner: strict count check
							if (!empty_q && (bad0_q || !strict_ok)) begin
								mode_q  <= MODE_IDLE;
								state_q <= S_STATUS;
							end else begin
								mode_q  <= dec_stop_idle ? MODE_IDLE : MODE_DECODE;
								state_q <= dec_run ? S_FETCH : S_STATUS;
							end
						end
						MODE_DECODE: begin
							if (dec_stop_idle) begin
								mode_q <= MODE_IDLE;
							end
							state_q <= dec_run ? S_FETCH : S_STATUS;
						end
						default: begin
							mode_q  <= banner_q ? MODE_BEGUN : MODE_IDLE;
							state_q <= S_STATUS;
						end
					endcase
				end

				S_FETCH: begin
					// read issued at k, data lands at k + 1
					if (k_q != 3'd0) begin
						grp_q[km1[1:0]] <= fch;
					end
					if (k_q == 3'd4) begin
						k_q     <= 3'd0;
						state_q <= pass2_q ? S_EMIT : S_CHECK;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end

				S_CHECK: begin
					ngrp_q <= ngrp_nx;
					if (!bad_grp && rem_q > 6'd3) begin
						p_q     <= p_q + SIZE_W'(4);
						rem_q   <= rem_q - 6'd3;
						state_q <= S_FETCH;
					end else begin
						// an invalid character closes the section
						if (bad_grp) begin
							mode_q <= MODE_IDLE;
						end
						if (ngrp_nx == 5'd0) begin
							state_q <= S_STATUS;
						end else begin
							p_q     <= SIZE_W'(1);
							rem_q   <= len_q;
							g_q     <= 5'd0;
							j_q     <= 2'd0;
							pass2_q <= 1'b1;
							state_q <= S_FETCH;
						end
					end
				end

				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= grp_byte;
						has_data_q  <= 1'b1;
						last_q      <= j_last && g_last;
						active_q    <= (mode_q != MODE_IDLE);
						if (j_last) begin
							j_q <= 2'd0;
							if (g_last) begin
								state_q <= S_IDLE;
							end else begin
								g_q     <= g_q + 5'd1;
								p_q     <= p_q + SIZE_W'(4);
								rem_q   <= rem_q - 6'd3;
								state_q <= S_FETCH;
							end
						end else begin
							j_q <= j_q + 2'd1;
						end
					end
				end

				S_STATUS: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= 8'd0;
						has_data_q  <= 1'b0;
						last_q      <= 1'b1;
						active_q    <= (mode_q != MODE_IDLE);
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
